>>> rtl/core/gated_frequency_counter_display_defines.svh
// Assertion macros shared by the gated frequency counter modules.
// Depends on nothing; each user provides signals named clock and reset.
`ifndef GATED_FREQUENCY_COUNTER_DISPLAY_DEFINES_SVH
`define GATED_FREQUENCY_COUNTER_DISPLAY_DEFINES_SVH
`ifndef SYNTHESIS
`define GFCD_ASSERT_ALWAYS(name, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");
`define GFCD_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define GFCD_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define GFCD_ASSERT_ALWAYS(name, expr)
`define GFCD_ASSERT_SAME(name, ante, cons)
`define GFCD_ASSERT_NEXT(name, ante, cons)
`endif
`endif

>>> rtl/core/gfcd_pkg.sv
// Shared constants, character codes and command/status types of the
// gated frequency counter. Depends on nothing.
`default_nettype none
package gfcd_pkg;

   localparam int COUNT_BITS = 32;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Decimal limits of the report format.
   localparam logic [COUNT_BITS-1:0] LIMIT_UNITS = COUNT_BITS'(1000);
   localparam logic [COUNT_BITS-1:0] LIMIT_UPPER_K = COUNT_BITS'(100000);
   localparam logic [COUNT_BITS-1:0] LIMIT_MEGA = COUNT_BITS'(1000000);

   // Binary to BCD conversion of counts below one million.
   localparam int BIN_BITS = 20;
   localparam int BCD_DIGITS = 6;
   localparam int STEP_BITS = $clog2(BIN_BITS);
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(BIN_BITS - 1);

   localparam logic [15:0] GATE_RESET = 16'd31250;

   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_UPPER_K = 8'h4B;
   localparam logic [7:0] CHAR_LOWER_K = 8'h6B;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_H = 8'h48;
   localparam logic [7:0] CHAR_Z = 8'h7A;

   typedef enum logic [2:0] {
      SEL_CLEAR,
      SEL_DIGIT,
      SEL_SUFFIX,
      SEL_SPACE,
      SEL_H,
      SEL_Z
   } char_sel_type;

   typedef struct packed {
      logic         item_accept;
      logic         convert_step;
      logic         load_index;
      logic         dec_index;
      char_sel_type char_sel;
   } command_type;

   typedef struct packed {
      logic window_end;
      logic conv_last;
      logic index_zero;
      logic below_units;
      logic at_mega;
   } status_type;

endpackage
`default_nettype wire

>>> rtl/core/gated_frequency_counter_display.sv
// Top level of the gated frequency counter with character report.
// Depends on gfcd_pkg, gfcd_controller and gfcd_datapath.
//
//   Channel   Direction  Handshake                    Payload
//   req       in         req_valid / req_ready        req_rising_edge, req_timer_tick
//   rsp       out        rsp_valid / rsp_ready        rsp_char_code, rsp_clear_screen,
//                                                     rsp_last
//   csr       in         csr_write_enable (no wait)   csr_write_data (gate ticks)
//
// Items that do not close the gate window are accepted back to back in every
// cycle.
// An item that closes the window is followed by binary to BCD conversion
// (one shift-and-adjust step per cycle), then by four to eight
// character transfers, one per cycle when rsp_ready stays high.
// Input is refused from the closing item until the cycle after the final 'z'
// transfer; a stall on rsp simply holds the current character.
// Synchronous active-high reset restores a gate of 31250 ticks and zero counts.
`default_nettype none
module gated_frequency_counter_display
   import gfcd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_rising_edge,
   input  wire logic        req_timer_tick,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_char_code,
   output logic             rsp_clear_screen,
   output logic             rsp_last,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data
);

   // Commands flow from the controller to the datapath, status the other way.
   command_type cmd;
   status_type  status;

   gfcd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath counts edges and ticks on each accepted transfer and forms
   // the character held on rsp while the controller presents it.
   gfcd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_rising_edge  (req_rising_edge),
      .req_timer_tick   (req_timer_tick),
      .cmd              (cmd),
      .status           (status),
      .rsp_char_code    (rsp_char_code),
      .rsp_clear_screen (rsp_clear_screen),
      .rsp_last         (rsp_last)
   );

endmodule
`default_nettype wire

>>> rtl/core/gfcd_datapath.sv
// Datapath: gate register, edge and tick counters, BCD conversion and
// character selection. Depends on gfcd_pkg and the defines header.
`default_nettype none
`include "gated_frequency_counter_display_defines.svh"
module gfcd_datapath
   import gfcd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data,
   input  wire logic        req_rising_edge,
   input  wire logic        req_timer_tick,
   input  wire command_type cmd,
   output status_type       status,
   output logic [7:0]       rsp_char_code,
   output logic             rsp_clear_screen,
   output logic             rsp_last
);

   logic [15:0]             gate_ff;
   logic [15:0]             tick_count_ff;
   logic [COUNT_BITS-1:0]   edge_count_ff;
   logic [COUNT_BITS-1:0]   report_count_ff;
   logic [BIN_BITS-1:0]     bin_ff;
   logic [4*BCD_DIGITS-1:0] bcd_ff;
   logic [STEP_BITS-1:0]    step_ff;
   logic [1:0]              index_ff;

   logic [15:0]             limit;
   logic [16:0]             tick_next;
   logic [COUNT_BITS-1:0]   edge_next;
   logic [4*BCD_DIGITS-1:0] bcd_adjusted;
   logic [3:0]              digit_sel [3];
   logic [1:0]              index_in;
   logic [3:0]              digit_out;
   logic                    upper_k;

   assign limit = (gate_ff == 16'd0) ? 16'd1 : gate_ff;
   assign tick_next = {1'b0, tick_count_ff} + 17'd1;
   assign edge_next = (req_rising_edge && (edge_count_ff != COUNT_MAX)) ?
                      edge_count_ff + COUNT_BITS'(1) : edge_count_ff;

   // Add three to every digit of five or more before the shift.
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         bcd_adjusted[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ?
                                  bcd_ff[4*i +: 4] + 4'd3 : bcd_ff[4*i +: 4];
      end
   end

   // Units digits for small counts, thousands digits otherwise.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         digit_sel[i] = status.below_units ? bcd_ff[4*i +: 4] : bcd_ff[4*(i+3) +: 4];
      end
   end

   assign index_in = (digit_sel[2] != 4'd0) ? 2'd2 :
                     (digit_sel[1] != 4'd0) ? 2'd1 : 2'd0;

   always_comb begin
      case (index_ff)
         2'd0:    digit_out = digit_sel[0];
         2'd1:    digit_out = digit_sel[1];
         default: digit_out = digit_sel[2];
      endcase
   end

   assign status.window_end = req_timer_tick && (tick_next >= {1'b0, limit});
   assign status.conv_last = (step_ff == LAST_STEP);
   assign status.index_zero = (index_ff == 2'd0);
   assign status.below_units = (report_count_ff < LIMIT_UNITS);
   assign status.at_mega = (report_count_ff >= LIMIT_MEGA);
   assign upper_k = (report_count_ff < LIMIT_UPPER_K);

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff <= GATE_RESET;
         tick_count_ff <= 16'd0;
         edge_count_ff <= '0;
         step_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            gate_ff <= csr_write_data;
         end
         if (cmd.item_accept) begin
            if (status.window_end) begin
               report_count_ff <= edge_next;
               bin_ff <= edge_next[BIN_BITS-1:0];
               bcd_ff <= '0;
               step_ff <= '0;
               edge_count_ff <= '0;
               tick_count_ff <= 16'd0;
            end else begin
               edge_count_ff <= edge_next;
               if (req_timer_tick) begin
                  tick_count_ff <= tick_next[15:0];
               end
            end
         end
         if (cmd.convert_step) begin
            bcd_ff <= {bcd_adjusted[4*BCD_DIGITS-2:0], bin_ff[BIN_BITS-1]};
            bin_ff <= {bin_ff[BIN_BITS-2:0], 1'b0};
            step_ff <= step_ff + STEP_BITS'(1);
         end
         if (cmd.load_index) begin
            index_ff <= index_in;
         end else if (cmd.dec_index) begin
            index_ff <= index_ff - 2'd1;
         end
      end
   end

   always_comb begin
      case (cmd.char_sel)
         SEL_CLEAR:  rsp_char_code = CHAR_NUL;
         SEL_DIGIT:  rsp_char_code = CHAR_ZERO + {4'd0, digit_out};
         SEL_SUFFIX: rsp_char_code = upper_k ? CHAR_UPPER_K : CHAR_LOWER_K;
         SEL_SPACE:  rsp_char_code = CHAR_SPACE;
         SEL_H:      rsp_char_code = CHAR_H;
         SEL_Z:      rsp_char_code = CHAR_Z;
         default:    rsp_char_code = CHAR_NUL;
      endcase
   end

   assign rsp_clear_screen = (cmd.char_sel == SEL_CLEAR);
   assign rsp_last = (cmd.char_sel == SEL_Z);

   `GFCD_ASSERT_NEXT(edge_cleared_after_window, cmd.item_accept && status.window_end,
      edge_count_ff == '0)
   `GFCD_ASSERT_NEXT(tick_cleared_after_window, cmd.item_accept && status.window_end,
      tick_count_ff == 16'd0)
   `GFCD_ASSERT_NEXT(edge_count_holds_at_max,
      cmd.item_accept && !status.window_end && edge_count_ff == COUNT_MAX,
      edge_count_ff == COUNT_MAX)

endmodule
`default_nettype wire

>>> rtl/core/gfcd_controller.sv
// Controller: sequences window capture, BCD conversion and the report
// characters. Depends on gfcd_pkg and the defines header.
`default_nettype none
`include "gated_frequency_counter_display_defines.svh"
module gfcd_controller
   import gfcd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output command_type     cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SEND
   } state_type;

   state_type    state_ff;
   logic         rsp_valid_ff;
   char_sel_type char_sel_ff;
   logic         send_done;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign send_done = (state_ff == ST_SEND) && rsp_ready;

   assign cmd.item_accept = req_valid && (state_ff == ST_IDLE);
   assign cmd.convert_step = (state_ff == ST_CONVERT);
   assign cmd.load_index = send_done && (char_sel_ff == SEL_CLEAR);
   assign cmd.dec_index = send_done && (char_sel_ff == SEL_DIGIT) && !status.index_zero;
   assign cmd.char_sel = char_sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         char_sel_ff <= SEL_CLEAR;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (cmd.item_accept && status.window_end) begin
                  state_ff <= ST_CONVERT;
               end
            end
            ST_CONVERT: begin
               if (status.conv_last) begin
                  state_ff <= ST_SEND;
                  rsp_valid_ff <= 1'b1;
                  char_sel_ff <= SEL_CLEAR;
               end
            end
            ST_SEND: begin
               if (rsp_ready) begin
                  case (char_sel_ff)
                     SEL_CLEAR:  char_sel_ff <= status.at_mega ? SEL_SPACE : SEL_DIGIT;
                     SEL_DIGIT: begin
                        if (status.index_zero) begin
                           char_sel_ff <= status.below_units ? SEL_SPACE : SEL_SUFFIX;
                        end
                     end
                     SEL_SUFFIX: char_sel_ff <= SEL_SPACE;
                     SEL_SPACE:  char_sel_ff <= SEL_H;
                     SEL_H:      char_sel_ff <= SEL_Z;
                     default: begin
                        rsp_valid_ff <= 1'b0;
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `GFCD_ASSERT_ALWAYS(no_input_during_report, !(req_ready && rsp_valid_ff))
   `GFCD_ASSERT_NEXT(ready_after_last_transfer,
      rsp_valid_ff && rsp_ready && char_sel_ff == SEL_Z, req_ready && !rsp_valid_ff)
   `GFCD_ASSERT_SAME(valid_only_when_sending, rsp_valid_ff, state_ff == ST_SEND)

endmodule
`default_nettype wire

>>> sim/tb_gated_frequency_counter_display.sv
// Self-checking testbench of the gated frequency counter with character report.
// Depends on gfcd_pkg and the gated_frequency_counter_display top level.
module tb_gated_frequency_counter_display
   import gfcd_pkg::*;
();

   // One character of a report as it leaves the block.
   typedef struct packed {
      logic [7:0] code;
      logic       clear;
      logic       last;
   } report_char_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_rising_edge = 1'b0;
   logic        req_timer_tick = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_char_code;
   logic        rsp_clear_screen;
   logic        rsp_last;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = 16'd0;

   // Mirror of the block's state, kept up to date at each accepted transfer.
   logic [15:0]     gate_setting = GATE_RESET;
   logic [COUNT_BITS-1:0] edges_seen = '0;
   logic [15:0]     ticks_seen = 16'd0;

   report_char_type pending_chars[$];
   report_char_type oldest_char;
   int              mismatches = 0;
   // When set, both channels insert random idle cycles.
   bit              gaps_on = 1'b0;

   gated_frequency_counter_display dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rising_edge  (req_rising_edge),
      .req_timer_tick   (req_timer_tick),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_char_code    (rsp_char_code),
      .rsp_clear_screen (rsp_clear_screen),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls at random, with a chance of roughly 23 percent, while gaps are
   // enabled, and is always ready otherwise.
   always @(negedge clock) begin
      rsp_ready <= !gaps_on || ($urandom_range(99) >= 23);
   end

   // Queues the characters of the report for a window that saw the given
   // number of edges. Below 1000 the count is shown as it is, below a million
   // it is shown in thousands with a K or k suffix, and from a million up only
   // the unit follows the clear marker.
   function automatic void queue_report(input logic [COUNT_BITS-1:0] count);
      logic [COUNT_BITS-1:0] shown;
      logic [7:0]            suffix;
      suffix = CHAR_NUL;
      pending_chars.push_back('{code: CHAR_NUL, clear: 1'b1, last: 1'b0});
      if (count < LIMIT_MEGA) begin
         if (count < LIMIT_UNITS) begin
            shown = count;
         end else begin
            shown = count / LIMIT_UNITS;
            suffix = (count < LIMIT_UPPER_K) ? CHAR_UPPER_K : CHAR_LOWER_K;
         end
         if (shown >= 100) begin
            pending_chars.push_back('{code: CHAR_ZERO + 8'(shown / 100), clear: 1'b0,
                                      last: 1'b0});
         end
         if (shown >= 10) begin
            pending_chars.push_back('{code: CHAR_ZERO + 8'((shown / 10) % 10), clear: 1'b0,
                                      last: 1'b0});
         end
         pending_chars.push_back('{code: CHAR_ZERO + 8'(shown % 10), clear: 1'b0,
                                   last: 1'b0});
         if (suffix != CHAR_NUL) begin
            pending_chars.push_back('{code: suffix, clear: 1'b0, last: 1'b0});
         end
      end
      pending_chars.push_back('{code: CHAR_SPACE, clear: 1'b0, last: 1'b0});
      pending_chars.push_back('{code: CHAR_H, clear: 1'b0, last: 1'b0});
      pending_chars.push_back('{code: CHAR_Z, clear: 1'b0, last: 1'b1});
   endfunction

   // Updates the mirrored counts for one accepted item. The edge is counted
   // before the tick, so an edge that arrives with the closing tick belongs to
   // the window it closes. A gate of zero behaves as a gate of one, and a gate
   // already passed by the tick count closes the window at the next tick.
   function automatic void count_item(input logic rising, input logic tick);
      int reached;
      int limit;
      if (rising && edges_seen != COUNT_MAX) begin
         edges_seen = edges_seen + COUNT_BITS'(1);
      end
      if (tick) begin
         reached = int'(ticks_seen) + 1;
         limit = (gate_setting == 16'd0) ? 1 : int'(gate_setting);
         if (reached >= limit) begin
            queue_report(edges_seen);
            edges_seen = '0;
            ticks_seen = 16'd0;
         end else begin
            ticks_seen = 16'(reached);
         end
      end
   endfunction

   // Offers one item and waits for its transfer. Idle cycles before the item
   // carry random payload bits that the block must ignore. Valid stays high
   // after the transfer until the next falling edge, where the caller either
   // offers another item or withdraws it.
   task automatic send_item(input logic rising, input logic tick);
      @(negedge clock);
      while (gaps_on && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         req_rising_edge <= 1'($urandom_range(1));
         req_timer_tick <= 1'($urandom_range(1));
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rising_edge <= rising;
      req_timer_tick <= tick;
      do begin
         @(posedge clock);
      end while (!req_ready);
      count_item(rising, tick);
   endtask

   task automatic withdraw_item;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Waits until every queued character has been transferred, then waits a
   // few more cycles so that the block is certainly idle.
   task automatic drain_reports;
      while (pending_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (40) @(posedge clock);
   endtask

   // Writes the gate length while the block is idle.
   task automatic write_gate(input logic [15:0] ticks);
      withdraw_item();
      drain_reports();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= ticks;
      gate_setting = ticks;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Closes a window of exactly the given count with a gate of one tick.
   task automatic window_of(input int count);
      for (int i = 1; i < count; i++) begin
         send_item(1'b1, 1'b0);
      end
      send_item(count != 0, 1'b1);
   endtask

   // With the gate at its reset length ten ticks produce no report. The gate
   // is then set to one more than the ticks counted, so the next tick closes
   // the window exactly at its length.
   task automatic test_reset_gate_exact_close;
      gaps_on = 1'b0;
      repeat (10) send_item(1'b1, 1'b1);
      write_gate(16'd11);
      send_item(1'b1, 1'b1);
   endtask

   // A gate of zero ends a window at every tick; covers the empty window and
   // an edge that arrives with its closing tick.
   task automatic test_zero_gate;
      gaps_on = 1'b1;
      write_gate(16'd0);
      send_item(1'b0, 1'b1);
      send_item(1'b1, 1'b1);
      send_item(1'b1, 1'b0);
      send_item(1'b1, 1'b0);
      send_item(1'b0, 1'b1);
   endtask

   // Lowering the gate below the ticks already counted closes the window at
   // the next tick.
   task automatic test_gate_lowered;
      gaps_on = 1'b1;
      write_gate(16'd10);
      repeat (5) send_item(1'b1, 1'b1);
      send_item(1'b1, 1'b0);
      send_item(1'b0, 1'b0);
      write_gate(16'd3);
      send_item(1'b1, 1'b1);
   endtask

   // Counts on either side of the changes from one to two and from two to three
   // digits shown, and the empty window.
   task automatic test_digit_widths;
      int counts[5];
      counts = '{9, 10, 99, 100, 0};
      gaps_on = 1'b1;
      write_gate(16'd1);
      foreach (counts[i]) begin
         window_of(counts[i]);
      end
   endtask

   // Phases of random items, each with its own gate and edge density. The
   // first and longest phase runs without idling.
   task automatic test_random_windows;
      int edge_pct;
      for (int phase = 0; phase < 3; phase++) begin
         gaps_on = (phase != 0);
         case (phase)
            0: write_gate(16'd2);
            1: write_gate(16'($urandom_range(3, 9)));
            default: write_gate(16'd0);
         endcase
         edge_pct = $urandom_range(10, 90);
         repeat ((phase == 0) ? 60 : 33) begin
            send_item($urandom_range(99) < edge_pct, $urandom_range(99) < 35);
         end
      end
   endtask

   // Every character transfer is compared with the oldest expected one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_chars.size() == 0) begin
            $error("char_code expected none actual %0h", rsp_char_code);
            mismatches++;
         end else begin
            oldest_char = pending_chars.pop_front();
            if (rsp_char_code !== oldest_char.code) begin
               $error("char_code expected %0h actual %0h", oldest_char.code, rsp_char_code);
               mismatches++;
            end
            if (rsp_clear_screen !== oldest_char.clear) begin
               $error("clear_screen expected %0b actual %0b", oldest_char.clear,
                      rsp_clear_screen);
               mismatches++;
            end
            if (rsp_last !== oldest_char.last) begin
               $error("last expected %0b actual %0b", oldest_char.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_gate_exact_close();
      test_zero_gate();
      test_gate_lowered();
      test_digit_widths();
      test_random_windows();
      withdraw_item();
      drain_reports();
      if (mismatches == 0) begin
         $display("gated_frequency_counter_display verification clean");
      end else begin
         $display("gated_frequency_counter_display verification failed");
      end
      $finish;
   end

   // The timeout allows many times the length of the whole run before
   // declaring the block hung.
   initial begin
      #2000000;
      $display("gated_frequency_counter_display verification failed");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/gfcd_pkg.sv
rtl/core/gfcd_datapath.sv
rtl/core/gfcd_controller.sv
rtl/core/gated_frequency_counter_display.sv
sim/tb_gated_frequency_counter_display.sv
